[hdl/rcpa_pkg.sv]
// Shared constants, types and request codes for the reference-counted page allocator.
// Used by rcpa_count_mem, rcpa_free_list and refcounted_page_allocator_unit.
// No dependencies.
package rcpa_pkg;

	// Geometry of the managed physical memory.
	localparam int NUM_PAGES        = 32768;
	localparam int PAGE_OFFSET_BITS = 12;
	localparam int PAGE_W           = $clog2(NUM_PAGES);

	// Field widths.
	localparam int ADDR_W = 32;
	localparam int CNT_W  = 15;
	localparam int OP_W   = 3;
	localparam int ST_W   = 3;
	localparam int CFG_W  = 16;
	localparam int CFG_IDX_W = 1;

	// Page number carried by an address, and a width that holds every page compare.
	localparam int PNUM_W  = ADDR_W - PAGE_OFFSET_BITS;
	localparam int MAX_A_W = (PNUM_W > CFG_W) ? PNUM_W : CFG_W;
	localparam int CMP_W   = ((MAX_A_W > PAGE_W) ? MAX_A_W : PAGE_W) + 2;

	typedef logic [PAGE_W-1:0] page_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	localparam cnt_t COUNT_MAX = '1;

	// Request opcodes.
	localparam logic [OP_W-1:0] OP_INIT  = 3'd0;
	localparam logic [OP_W-1:0] OP_ALLOC = 3'd1;
	localparam logic [OP_W-1:0] OP_FREE  = 3'd2;
	localparam logic [OP_W-1:0] OP_DUP   = 3'd3;
	localparam logic [OP_W-1:0] OP_QUERY = 3'd4;

	// Result status codes.
	localparam logic [ST_W-1:0] ST_OK      = 3'd0;
	localparam logic [ST_W-1:0] ST_OOM     = 3'd1;
	localparam logic [ST_W-1:0] ST_BADADDR = 3'd2;
	localparam logic [ST_W-1:0] ST_UNDER   = 3'd3;
	localparam logic [ST_W-1:0] ST_OVER    = 3'd4;

	// Configuration register indexes and reset values.
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PAGE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_STOP_PAGE  = 1'b1;
	localparam logic [CFG_W-1:0]     FIRST_RESET    = 16'd0;
	localparam logic [CFG_W-1:0]     STOP_RESET     = 16'd32768;

	// Write request into the count memory.
	typedef struct packed {
		logic  en;
		page_t addr;
		cnt_t  data;
	} cnt_wr_t;

	// Commands to the free list.
	typedef struct packed {
		logic  clear;
		logic  push;
		page_t push_page;
		logic  pop_rd;
		logic  pop_commit;
	} fl_cmd_t;

endpackage

[hdl/rcpa_count_mem.sv]
// Reference count memory: one synchronous read port, one write port, and a
// clearing sweep after reset that zeroes every entry. Depends on rcpa_pkg.
module rcpa_count_mem (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            rd_en,
	input  rcpa_pkg::page_t rd_addr,
	output rcpa_pkg::cnt_t  rd_data,
	input  rcpa_pkg::cnt_wr_t wr,
	output logic            busy
);
	import rcpa_pkg::*;

	cnt_t  mem [NUM_PAGES];
	cnt_t  rd_q;
	page_t clr_q;
	logic  busy_q;
	logic  we;
	page_t wa;
	cnt_t  wd;

	// The clearing sweep owns the write port until it has visited every entry.
	always_comb begin
		if (busy_q) begin
			we = 1'b1;
			wa = clr_q;
			wd = '0;
		end else begin
			we = wr.en;
			wa = wr.addr;
			wd = wr.data;
		end
	end

	// Sweep counter, one entry a cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			clr_q  <= '0;
		end else if (busy_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == page_t'(NUM_PAGES - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Memory array; read data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;
	assign busy    = busy_q;

endmodule

[hdl/rcpa_free_list.sv]
// LIFO free list: head register, empty flag and a link memory whose entries
// carry a further-page flag next to the link. Depends on rcpa_pkg.
module rcpa_free_list (
	input  logic              clk,
	input  logic              arst_n,
	input  rcpa_pkg::fl_cmd_t cmd,
	output rcpa_pkg::page_t   head,
	output logic              empty
);
	import rcpa_pkg::*;

	// Link entry: flag that a further free page follows, then its number.
	logic [PAGE_W:0] link_mem [NUM_PAGES];
	logic [PAGE_W:0] link_rd_q;
	page_t           head_q;
	logic            empty_q;

	// Head and empty flag follow clear, push and the end of a pop.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			empty_q <= 1'b1;
		end else begin
			priority if (cmd.clear) begin
				head_q  <= '0;
				empty_q <= 1'b1;
			end else if (cmd.push) begin
				head_q  <= cmd.push_page;
				empty_q <= 1'b0;
			end else if (cmd.pop_commit) begin
				if (link_rd_q[PAGE_W]) begin
					head_q <= link_rd_q[PAGE_W-1:0];
				end else begin
					head_q  <= '0;
					empty_q <= 1'b1;
				end
			end
		end
	end

	// A push links the new head to the old one; a pop reads the head's link.
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			link_mem[cmd.push_page] <= {~empty_q, head_q};
		end
		if (cmd.pop_rd) begin
			link_rd_q <= link_mem[head_q];
		end
	end

	assign head  = head_q;
	assign empty = empty_q;

endmodule

[hdl/refcounted_page_allocator_unit.sv]
// Reference-counted page allocator, top level: request control, address
// checks and the result register. Depends on rcpa_pkg, rcpa_count_mem, rcpa_free_list.

// After reset the count memory is swept to zero; during the sweep
// no request is accepted (configuration writes are). Alloc, free, dup and query
// each issue the memory read in the accept cycle; in the exec state, once the
// output register can take a result, the block modifies and writes back the count
// and link memories and loads the result register. Init walks the window, one page
// pushed per cycle through the single write port of each memory. A new request is
// accepted while the previous result still waits in the output register.
module refcounted_page_allocator_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rcpa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rcpa_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [rcpa_pkg::OP_W-1:0]     opcode,
	input  logic [rcpa_pkg::ADDR_W-1:0]   phys_address,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [rcpa_pkg::ST_W-1:0]     status,
	output logic [rcpa_pkg::ADDR_W-1:0]   page_address,
	output logic [rcpa_pkg::CNT_W-1:0]    ref_count,
	output logic                          page_released
);
	import rcpa_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_INIT = 2'd2;

	logic [1:0]       state_q;
	logic [CFG_W-1:0] first_q;
	logic [CFG_W-1:0] stop_q;
	logic [OP_W-1:0]  op_q;
	page_t            pg_q;
	logic             ok_q;
	page_t            walk_q;
	page_t            last_q;

	logic             out_valid_q;
	logic [ST_W-1:0]  status_q;
	logic [ADDR_W-1:0] paddr_q;
	cnt_t             count_q;
	logic             released_q;

	logic [CMP_W-1:0] pnum_c;
	logic [CMP_W-1:0] first_c;
	logic [CMP_W-1:0] stop_c;
	logic [CMP_W-1:0] eff_stop_c;
	logic             aligned_c;
	logic             in_range_c;
	logic             query_ok_c;
	logic             init_empty_c;
	logic             accept;
	logic             exec_fire;

	cnt_t             cnt_rd;
	logic             cnt_busy;
	cnt_wr_t          cnt_wr;
	fl_cmd_t          fl_cmd;
	page_t            fl_head;
	logic             fl_empty;

	logic [ST_W-1:0]   res_status;
	logic [ADDR_W-1:0] res_paddr;
	cnt_t              res_count;
	logic              res_released;
	logic              ex_cnt_we;
	cnt_t              ex_cnt_wd;
	page_t             ex_cnt_wa;
	logic              ex_push;
	logic              ex_pop;

	// Handshakes.
	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE) && !cnt_busy;
	assign accept    = in_valid && in_ready;
	assign exec_fire = (state_q == S_EXEC) && (!out_valid_q || out_ready);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= FIRST_RESET;
			stop_q  <= STOP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_FIRST_PAGE: first_q <= cfg_data;
				CFG_STOP_PAGE:  stop_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Address decode and the managed range.
	always_comb begin
		pnum_c       = CMP_W'(phys_address[ADDR_W-1:PAGE_OFFSET_BITS]);
		first_c      = CMP_W'(first_q);
		stop_c       = CMP_W'(stop_q);
		eff_stop_c   = (stop_c > CMP_W'(NUM_PAGES)) ? CMP_W'(NUM_PAGES) : stop_c;
		aligned_c    = (phys_address[PAGE_OFFSET_BITS-1:0] == '0);
		in_range_c   = aligned_c && (pnum_c >= first_c) && (pnum_c < eff_stop_c);
		query_ok_c   = pnum_c < CMP_W'(NUM_PAGES);
		init_empty_c = first_c >= eff_stop_c;
	end

	// Request sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= ((opcode == OP_INIT) && !init_empty_c) ? S_INIT : S_EXEC;
					end
				end
				S_INIT: begin
					if (walk_q == last_q) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (exec_fire) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Request fields captured at accept, and the init walk counter.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= opcode;
			pg_q   <= pnum_c[PAGE_W-1:0];
			ok_q   <= (opcode == OP_QUERY) ? query_ok_c : in_range_c;
			walk_q <= first_c[PAGE_W-1:0];
			last_q <= PAGE_W'(eff_stop_c - 1'b1);
		end else if (state_q == S_INIT) begin
			walk_q <= walk_q + 1'b1;
		end
	end

	// Result and write-back of the read-modify-write cycle.
	always_comb begin
		res_status   = ST_OK;
		res_paddr    = '0;
		res_count    = '0;
		res_released = 1'b0;
		ex_cnt_we    = 1'b0;
		ex_cnt_wa    = pg_q;
		ex_cnt_wd    = '0;
		ex_push      = 1'b0;
		ex_pop       = 1'b0;
		unique case (op_q)
			OP_ALLOC: begin
				if (fl_empty) begin
					res_status = ST_OOM;
				end else begin
					ex_pop    = 1'b1;
					ex_cnt_we = 1'b1;
					ex_cnt_wa = fl_head;
					ex_cnt_wd = cnt_t'(1);
					res_count = cnt_t'(1);
					res_paddr = ADDR_W'(fl_head) << PAGE_OFFSET_BITS;
				end
			end
			OP_FREE: begin
				priority if (!ok_q) begin
					res_status = ST_BADADDR;
				end else if (cnt_rd == '0) begin
					res_status = ST_UNDER;
				end else begin
					ex_cnt_we    = 1'b1;
					ex_cnt_wd    = cnt_rd - 1'b1;
					res_count    = cnt_rd - 1'b1;
					ex_push      = (cnt_rd == cnt_t'(1));
					res_released = (cnt_rd == cnt_t'(1));
				end
			end
			OP_DUP: begin
				priority if (!ok_q) begin
					res_status = ST_BADADDR;
				end else if (cnt_rd == '0) begin
					res_status = ST_UNDER;
				end else if (cnt_rd == COUNT_MAX) begin
					res_status = ST_OVER;
					res_count  = cnt_rd;
				end else begin
					ex_cnt_we = 1'b1;
					ex_cnt_wd = cnt_rd + 1'b1;
					res_count = cnt_rd + 1'b1;
				end
			end
			OP_QUERY: begin
				if (!ok_q) begin
					res_status = ST_BADADDR;
				end else begin
					res_count = cnt_rd;
				end
			end
			default: ;
		endcase
	end

	// Count memory write port: init walk or the write-back cycle.
	always_comb begin
		cnt_wr = '0;
		if (state_q == S_INIT) begin
			cnt_wr.en   = 1'b1;
			cnt_wr.addr = walk_q;
		end else if (exec_fire) begin
			cnt_wr.en   = ex_cnt_we;
			cnt_wr.addr = ex_cnt_wa;
			cnt_wr.data = ex_cnt_wd;
		end
	end

	// Free list commands.
	always_comb begin
		fl_cmd            = '0;
		fl_cmd.clear      = accept && (opcode == OP_INIT);
		fl_cmd.pop_rd     = accept && (opcode == OP_ALLOC);
		fl_cmd.pop_commit = exec_fire && ex_pop;
		if (state_q == S_INIT) begin
			fl_cmd.push      = 1'b1;
			fl_cmd.push_page = walk_q;
		end else if (exec_fire && ex_push) begin
			fl_cmd.push      = 1'b1;
			fl_cmd.push_page = pg_q;
		end
	end

	rcpa_count_mem u_count_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (pnum_c[PAGE_W-1:0]),
		.rd_data (cnt_rd),
		.wr      (cnt_wr),
		.busy    (cnt_busy)
	);

	rcpa_free_list u_free_list (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (fl_cmd),
		.head   (fl_head),
		.empty  (fl_empty)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_fire) begin
			status_q   <= res_status;
			paddr_q    <= res_paddr;
			count_q    <= res_count;
			released_q <= res_released;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign page_address  = paddr_q;
	assign ref_count     = count_q;
	assign page_released = released_q;

`ifndef ASSERT_OFF
	// An accepted request always leaves the idle state.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != S_IDLE))
		else $error("accepted request did not start");

	// No request is taken while the count memory is being cleared.
	a_clear_block: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_busy |-> !in_ready)
		else $error("request accepted during clearing sweep");

	// A released page is reported only by a successful free that reached zero.
	a_release_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && page_released) |-> ((status == ST_OK) && (ref_count == '0)))
		else $error("release reported with nonzero count or error");

	// A failed allocation never hands out an address.
	a_oom_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == ST_OOM)) |-> (page_address == '0))
		else $error("out of memory result carries an address");

	// A pop is only committed while the list holds a page.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		fl_cmd.pop_commit |-> !fl_empty)
		else $error("pop from empty free list");
`endif

endmodule

[tb/refcounted_page_allocator_unit_test.sv]
// Self-checking testbench for the reference-counted page allocator.
// Holds its own free-list and count model and checks every result in order.
// Depends on rcpa_pkg and refcounted_page_allocator_unit.
module refcounted_page_allocator_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import rcpa_pkg::*;

	// Opcodes that the block leaves without effect.
	localparam logic [OP_W-1:0] OP_RSVD_FIRST = 3'd5;
	localparam logic [OP_W-1:0] OP_RSVD_LAST  = 3'd7;

	localparam int WATCHDOG_LIMIT = 150000;
	localparam int LONG_STALL     = 400;
	localparam int DRAIN_CYCLES   = 40;
	localparam int WINDOW_MAX     = 40;
	localparam int MAX_REPORTS    = 10;
	localparam int DUP_RUN        = 20;

	typedef struct packed {
		logic [ST_W-1:0]   status;
		logic [ADDR_W-1:0] page_address;
		cnt_t              ref_count;
		logic              page_released;
	} page_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [OP_W-1:0]      opcode;
	logic [ADDR_W-1:0]    phys_address;
	logic                 out_valid;
	logic                 out_ready;
	logic [ST_W-1:0]      status;
	logic [ADDR_W-1:0]    page_address;
	logic [CNT_W-1:0]     ref_count;
	logic                 page_released;

	// Model state: counts, LIFO links and the two registers.
	cnt_t       page_counts [NUM_PAGES];
	page_t      page_links [NUM_PAGES];
	bit         page_link_ok [NUM_PAGES];
	page_t      free_top = '0;
	bit         free_none = 1'b1;
	logic [CFG_W-1:0] cfg_first = FIRST_RESET;
	logic [CFG_W-1:0] cfg_stop  = STOP_RESET;

	page_result_t pending_results [$];

	bit gaps_on = 1'b1;
	int stall_request = 0;
	int mismatch_count = 0;
	int requests_sent = 0;
	int results_checked = 0;
	int settings_applied = 0;
	int quiet_cycles = 0;

	refcounted_page_allocator_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.opcode        (opcode),
		.phys_address  (phys_address),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.page_address  (page_address),
		.ref_count     (ref_count),
		.page_released (page_released)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Top of the managed range after clamping to the memory size.
	function automatic int unsigned eff_stop();
		return (cfg_stop > NUM_PAGES) ? NUM_PAGES : cfg_stop;
	endfunction

	function automatic logic [ADDR_W-1:0] page_addr(int unsigned pg);
		return ADDR_W'(pg) << PAGE_OFFSET_BITS;
	endfunction

	function automatic void push_free(page_t pg);
		page_links[pg] = free_top;
		page_link_ok[pg] = !free_none;
		free_top = pg;
		free_none = 1'b0;
	endfunction

	// Applies one request to the model and returns the result it must produce.
	function automatic page_result_t predict_page_op(logic [OP_W-1:0] op,
			logic [ADDR_W-1:0] addr);
		page_result_t r;
		logic [PNUM_W-1:0] pnum;
		page_t pg;
		int unsigned stop_lim;
		bit managed;
		r = '0;
		pnum = addr[ADDR_W-1:PAGE_OFFSET_BITS];
		pg = pnum[PAGE_W-1:0];
		stop_lim = eff_stop();
		managed = (addr[PAGE_OFFSET_BITS-1:0] == '0) && (pnum >= cfg_first) &&
			(pnum < stop_lim);
		case (op)
			OP_INIT: begin
				free_none = 1'b1;
				free_top = '0;
				for (int unsigned p = cfg_first; p < stop_lim; p++) begin
					page_counts[p] = '0;
					push_free(page_t'(p));
				end
			end
			OP_ALLOC: begin
				if (free_none) begin
					r.status = ST_OOM;
				end else begin
					pg = free_top;
					if (page_link_ok[pg]) begin
						free_top = page_links[pg];
					end else begin
						free_none = 1'b1;
						free_top = '0;
					end
					page_counts[pg] = cnt_t'(1);
					r.ref_count = cnt_t'(1);
					r.page_address = page_addr(pg);
				end
			end
			OP_FREE, OP_DUP: begin
				if (!managed) begin
					r.status = ST_BADADDR;
				end else if (page_counts[pg] == '0) begin
					r.status = ST_UNDER;
				end else if (op == OP_FREE) begin
					page_counts[pg] = page_counts[pg] - cnt_t'(1);
					r.ref_count = page_counts[pg];
					if (page_counts[pg] == '0) begin
						push_free(pg);
						r.page_released = 1'b1;
					end
				end else if (page_counts[pg] == COUNT_MAX) begin
					r.status = ST_OVER;
					r.ref_count = page_counts[pg];
				end else begin
					page_counts[pg] = page_counts[pg] + cnt_t'(1);
					r.ref_count = page_counts[pg];
				end
			end
			OP_QUERY: begin
				if (pnum >= NUM_PAGES)
					r.status = ST_BADADDR;
				else
					r.ref_count = page_counts[pg];
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, page_result_t want, page_result_t got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS) begin
			$write("[%0t] %s: expected st=%0d addr=%h cnt=%0d rel=%0b,",
				$realtime, what, want.status, want.page_address, want.ref_count,
				want.page_released);
			$display(" got st=%0d addr=%h cnt=%0d rel=%0b",
				got.status, got.page_address, got.ref_count, got.page_released);
		end
	endtask

	// Sends one request, with an optional gap in front, and records its result.
	task automatic send_req(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr);
		@(negedge clk);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		in_valid = 1'b1;
		opcode = op;
		phys_address = addr;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(predict_page_op(op, addr));
		requests_sent++;
	endtask

	// Drops the request line and waits until every result is back.
	task automatic wait_idle();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
	endtask

	// Writes one register while the block is idle.
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		wait_idle();
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_FIRST_PAGE)
			cfg_first = val;
		else
			cfg_stop = val;
		settings_applied++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Address mix for random requests: mostly inside the window, some outside or junk.
	function automatic logic [ADDR_W-1:0] pick_address();
		int unsigned lo;
		int unsigned hi;
		int unsigned pg;
		lo = cfg_first;
		hi = eff_stop();
		pg = (lo < hi) ? $urandom_range(lo, hi - 1) : $urandom_range(0, NUM_PAGES - 1);
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return page_addr(pg);
			6: return page_addr($urandom_range(0, NUM_PAGES - 1));
			7: return page_addr(pg) | ADDR_W'($urandom_range(1, (1 << PAGE_OFFSET_BITS) - 1));
			8: return $urandom();
			default: return page_addr($urandom_range(0, 1) ? lo - 1 : hi);
		endcase
	endfunction

	// Requests against the state right after reset: empty list, zero counts.
	task automatic test_reset_defaults();
		send_req(OP_QUERY, page_addr(0));
		send_req(OP_QUERY, page_addr(NUM_PAGES - 1));
		send_req(OP_QUERY, page_addr(NUM_PAGES));
		send_req(OP_QUERY, '1);
		send_req(OP_ALLOC, '0);
		send_req(OP_FREE, page_addr(3));
		send_req(OP_DUP, page_addr(3));
		send_req(OP_FREE, page_addr(3) + 4);
		for (int op = OP_RSVD_FIRST; op <= OP_RSVD_LAST; op++)
			send_req(OP_W'(op), '1);
	endtask

	// Whole memory managed, stop register above the memory size.
	task automatic test_full_range_init();
		cfg_write(CFG_FIRST_PAGE, FIRST_RESET);
		cfg_write(CFG_STOP_PAGE, '1);
		send_req(OP_INIT, '0);
		send_req(OP_ALLOC, '0);
		send_req(OP_ALLOC, '0);
		send_req(OP_FREE, page_addr(NUM_PAGES - 1));
		send_req(OP_ALLOC, '0);
		send_req(OP_DUP, page_addr(NUM_PAGES - 2));
		send_req(OP_FREE, page_addr(NUM_PAGES - 2));
		send_req(OP_QUERY, page_addr(NUM_PAGES - 2));
	endtask

	// Small window: exhaustion, range edges, double free, counts kept outside.
	task automatic test_window_edges();
		cfg_write(CFG_FIRST_PAGE, 16'd8);
		cfg_write(CFG_STOP_PAGE, 16'd12);
		send_req(OP_INIT, '0);
		repeat (5) send_req(OP_ALLOC, '0);
		send_req(OP_FREE, page_addr(7));
		send_req(OP_FREE, page_addr(12));
		send_req(OP_FREE, page_addr(8));
		send_req(OP_FREE, page_addr(8));
		send_req(OP_DUP, page_addr(9));
		send_req(OP_QUERY, page_addr(NUM_PAGES - 1));
	endtask

	// Empty ranges leave the list empty after init.
	task automatic test_empty_window();
		cfg_write(CFG_FIRST_PAGE, 16'd20);
		cfg_write(CFG_STOP_PAGE, 16'd20);
		send_req(OP_INIT, '0);
		send_req(OP_ALLOC, '0);
		send_req(OP_FREE, page_addr(20));
		cfg_write(CFG_FIRST_PAGE, '1);
		cfg_write(CFG_STOP_PAGE, '0);
		send_req(OP_INIT, '0);
		send_req(OP_ALLOC, '0);
	endtask

	// Raises one page's count with repeated duplicates, then frees it down
	// to zero and once more past it.
	task automatic test_count_saturation();
		cfg_write(CFG_FIRST_PAGE, 16'd100);
		cfg_write(CFG_STOP_PAGE, 16'd101);
		send_req(OP_INIT, '0);
		send_req(OP_ALLOC, '0);
		repeat (DUP_RUN) send_req(OP_DUP, page_addr(100));
		send_req(OP_QUERY, page_addr(100));
		repeat (DUP_RUN + 1) send_req(OP_FREE, page_addr(100));
		send_req(OP_FREE, page_addr(100));
	endtask

	// The receiver holds off long enough for the block to stall its input.
	task automatic test_backpressure();
		cfg_write(CFG_FIRST_PAGE, 16'd0);
		cfg_write(CFG_STOP_PAGE, 16'd16);
		send_req(OP_INIT, '0);
		stall_request = LONG_STALL;
		repeat (12) send_req(OP_ALLOC, '0);
		repeat (4) send_req(OP_QUERY, pick_address());
	endtask

	// Random phases: a new window, an init, then a weighted request mix.
	task automatic test_random_traffic(int phases, int per_phase);
		logic [CFG_W-1:0] lo;
		logic [CFG_W-1:0] hi;
		int sel;
		repeat (phases) begin
			case ($urandom_range(0, 9))
				0: begin
					lo = '0;
					hi = CFG_W'($urandom_range(1, 24));
				end
				1: begin
					lo = CFG_W'(NUM_PAGES - $urandom_range(1, 24));
					hi = '1;
				end
				2: begin
					lo = CFG_W'($urandom());
					hi = lo;
				end
				3: begin
					lo = CFG_W'($urandom());
					hi = lo + CFG_W'($urandom_range(0, WINDOW_MAX));
				end
				4: begin
					lo = CFG_W'($urandom_range(1, WINDOW_MAX));
					hi = lo - CFG_W'($urandom_range(1, lo));
				end
				default: begin
					lo = CFG_W'($urandom_range(0, NUM_PAGES - WINDOW_MAX));
					hi = lo + CFG_W'($urandom_range(1, WINDOW_MAX));
				end
			endcase
			cfg_write(CFG_FIRST_PAGE, lo);
			cfg_write(CFG_STOP_PAGE, hi);
			send_req(OP_INIT, $urandom());
			repeat (per_phase) begin
				sel = $urandom_range(0, 99);
				if (sel < 28)
					send_req(OP_ALLOC, $urandom());
				else if (sel < 53)
					send_req(OP_FREE, pick_address());
				else if (sel < 68)
					send_req(OP_DUP, pick_address());
				else if (sel < 83)
					send_req(OP_QUERY, pick_address());
				else if (sel < 86)
					send_req(OP_INIT, $urandom());
				else if (sel < 88)
					send_req(OP_W'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST)), $urandom());
				else
					send_req(OP_W'($urandom()), $urandom());
			end
		end
	endtask

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_request > 0) begin
				out_ready = 1'b0;
				repeat (stall_request) @(negedge clk);
				stall_request = 0;
			end else if (gaps_on && $urandom_range(0, 5) == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(1, 13)) @(negedge clk);
			end
			out_ready = 1'b1;
		end
	end

	// Compares each result with the oldest outstanding expectation.
	always @(posedge clk) begin : check_results
		page_result_t got;
		page_result_t want;
		if (arst_n && out_valid && out_ready) begin
			got.status = status;
			got.page_address = page_address;
			got.ref_count = ref_count;
			got.page_released = page_released;
			if (pending_results.size() == 0) begin
				report_mismatch("result with no request outstanding", '0, got);
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (got.status !== want.status || got.page_address !== want.page_address ||
						got.ref_count !== want.ref_count ||
						got.page_released !== want.page_released)
					report_mismatch("result mismatch", want, got);
			end
		end
	end

	// Watchdog: ends the run when nothing moves for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog expired after %0d idle cycles", quiet_cycles);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// Test sequence.
	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_FIRST_PAGE;
		cfg_data = '0;
		in_valid = 1'b0;
		opcode = OP_INIT;
		phys_address = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_full_range_init();
		test_window_edges();
		test_empty_window();
		test_count_saturation();
		test_backpressure();
		gaps_on = 1'b1;
		test_random_traffic(7, 86);
		gaps_on = 1'b0;
		test_random_traffic(1, 86);

		wait_idle();
		repeat (DRAIN_CYCLES) @(negedge clk);
		while (pending_results.size() != 0)
			report_mismatch("result never arrived", pending_results.pop_front(), '0);

		$display("Covered %0d requests, %0d results checked, %0d register writes;",
			requests_sent, results_checked, settings_applied);
		$display("full-range init, repeated duplicates and a %0d-cycle output stall included.",
			LONG_STALL);
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
